>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, hold off while reset is asserted.
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pip_pkg;

  localparam int VERTEX_COUNT_DEF = 16;
  localparam int COORD_W          = 20;
  localparam int SLOT_W           = 4;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic wr_en;   // write incoming vertex
    logic pt_ld;   // latch query point, clear parity
    logic rd_en;   // read one vertex
    logic first;   // this read opens the sweep
  } pip_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;     // read or edge pipeline still holds work
    logic in_poly;  // box check and parity of the finished sweep
  } pip_sts_t;

endpackage

>>> hw/rtl/pip_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_dp
// Vertex memory, bounding box tracker and edge crossing pipeline.
// ---------------------------------------------------------------------------
module pip_dp #(
  parameter int VERTEX_COUNT = pip_pkg::VERTEX_COUNT_DEF,
  localparam int AW = $clog2(VERTEX_COUNT)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pip_pkg::pip_cmd_t                  cmd_i,
  input  logic [AW-1:0]                      rd_addr_i,
  input  logic [pip_pkg::SLOT_W-1:0]         vertex_slot_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y_i,
  output pip_pkg::pip_sts_t                  sts_o
);

  localparam int CW = pip_pkg::COORD_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;

  // Vertex memory, y in the upper half
  logic [2*CW-1:0]         mem_q [VERTEX_COUNT];
  logic [VERTEX_COUNT-1:0] vld_q;
  logic [2*CW-1:0]         rd_data_q;
  logic                    rd_vld_q;

  logic          slot_ok;
  logic [AW-1:0] wr_addr;

  assign slot_ok = 32'(vertex_slot_i) < 32'(VERTEX_COUNT);
  assign wr_addr = AW'(vertex_slot_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      mem_q[wr_addr] <= {coord_y_i, coord_x_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && slot_ok) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Stage 1: current vertex against the previous one
  logic s1_vld_q, s1_first_q, s2_vld_q;
  logic signed [CW-1:0] cur_x, cur_y;
  logic signed [CW-1:0] px_q, py_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [DW-1:0] dx_p, dy, dx_e, dy_p;
  logic signed [PW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;
  logic                 straddle_d, straddle_q, dy_pos_q;
  logic                 parity_q, left, box_out;

  // Unwritten entries read as the origin
  assign cur_x = rd_vld_q ? $signed(rd_data_q[CW-1:0])    : '0;
  assign cur_y = rd_vld_q ? $signed(rd_data_q[2*CW-1:CW]) : '0;

  assign dx_p = DW'(px_q)     - DW'(cur_x);
  assign dy   = DW'(prev_y_q) - DW'(cur_y);
  assign dx_e = DW'(prev_x_q) - DW'(cur_x);
  assign dy_p = DW'(py_q)     - DW'(cur_y);

  assign lhs_d      = PW'(dx_p) * PW'(dy);
  assign rhs_d      = PW'(dx_e) * PW'(dy_p);
  assign straddle_d = (cur_y >= py_q) != (prev_y_q >= py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      parity_q   <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s2_vld_q   <= s1_vld_q && !s1_first_q;
      if (cmd_i.pt_ld) begin
        parity_q <= 1'b0;
      end else if (s2_vld_q && straddle_q && left) begin
        parity_q <= !parity_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_ld) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (s1_vld_q) begin
      prev_x_q   <= cur_x;
      prev_y_q   <= cur_y;
      lhs_q      <= lhs_d;
      rhs_q      <= rhs_d;
      straddle_q <= straddle_d;
      dy_pos_q   <= !dy[DW-1];
      if (s1_first_q) begin
        min_x_q <= cur_x;
        max_x_q <= cur_x;
        min_y_q <= cur_y;
        max_y_q <= cur_y;
      end else begin
        if (cur_x < min_x_q) min_x_q <= cur_x;
        if (cur_x > max_x_q) max_x_q <= cur_x;
        if (cur_y < min_y_q) min_y_q <= cur_y;
        if (cur_y > max_y_q) max_y_q <= cur_y;
      end
    end
  end

  // Stage 2: sign-corrected crossing compare
  assign left = dy_pos_q ? (lhs_q <= rhs_q) : (lhs_q >= rhs_q);

  assign box_out = (px_q < min_x_q) || (py_q < min_y_q) ||
                   (px_q > max_x_q) || (py_q > max_y_q);

  assign sts_o.busy    = s1_vld_q || s2_vld_q;
  assign sts_o.in_poly = parity_q && !box_out;

endmodule

>>> hw/rtl/pip_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_ctrl
// Sequencer for loads and vertex sweeps, plus the result output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_ctrl #(
  parameter int VERTEX_COUNT = pip_pkg::VERTEX_COUNT_DEF,
  localparam int AW = $clog2(VERTEX_COUNT),
  localparam int NW = $clog2(VERTEX_COUNT + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  inside_res_o,
  output pip_pkg::pip_cmd_t     cmd_o,
  output logic [AW-1:0]         rd_addr_o,
  input  pip_pkg::pip_sts_t     sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e        state_q;
  logic [NW-1:0] cnt_q;
  logic          is_query_q;
  logic          out_valid_q, out_inside_q;
  logic          in_acc, out_free;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cmd_o.wr_en = in_acc && (kind_i == pip_pkg::KIND_LOAD);
  assign cmd_o.pt_ld = in_acc && (kind_i == pip_pkg::KIND_QUERY);
  assign cmd_o.rd_en = state_q == ST_SWEEP;
  assign cmd_o.first = cnt_q == '0;

  // Last vertex first so it seeds the wrap-around edge
  assign rd_addr_o = (cnt_q == '0) ? AW'(VERTEX_COUNT - 1) : AW'(cnt_q - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      is_query_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_inside_q <= 1'b0;
    end else begin
      // Drop the word once taken, unless FINISH refills the register
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            is_query_q <= kind_i == pip_pkg::KIND_QUERY;
            state_q    <= (kind_i == pip_pkg::KIND_QUERY) ? ST_SWEEP : ST_FINISH;
          end
        end
        ST_SWEEP: begin
          cnt_q <= cnt_q + NW'(1);
          if (cnt_q == NW'(VERTEX_COUNT)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sts_i.busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_inside_q <= is_query_q && sts_i.in_poly;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_inside_q;

  `PIP_ASSERT(a_acc_idle, in_acc |-> state_q == ST_IDLE, "item accepted outside idle")
  `PIP_ASSERT(a_query_sweep, cmd_o.pt_ld |=> state_q == ST_SWEEP, "query did not start sweep")
  `PIP_ASSERT(a_finish_drained, (state_q == ST_FINISH && is_query_q) |-> !sts_i.busy,
    "result taken before edge pipeline drained")
  `PIP_ASSERT_ALWAYS(a_rd_range, cmd_o.rd_en |-> 32'(rd_addr_o) < 32'(VERTEX_COUNT),
    "vertex read beyond polygon")

endmodule

>>> hw/rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a query point against a stored closed polygon.
// ---------------------------------------------------------------------------
// Usage: one input channel (in_valid_i / in_stall_o) carries a word that
// either loads one vertex (kind_i = 0, vertex_slot_i picks its slot in
// polygon order) or queries a point (kind_i = 1). Coordinates are signed
// Q12.8. Every word gives exactly one result word on the output channel
// (out_valid_o / out_stall_i): inside_res_o, always 0 for a load.
// Timing: a load goes straight to the output register, and the next word is
// taken once that result is written. A query sweeps the vertex memory one read per
// cycle (VERTEX_COUNT + 1 reads, the last vertex first to close the polygon),
// then drains a two-stage edge pipeline before its result is registered, and
// the next word is taken once that result is written. The single memory read
// port sets the length of the sweep.
// Reset: all vertices read as (0, 0) until written; no clearing pass.
// A stalled result holds in the output register; the next word may be taken
// meanwhile, and its result waits until the register frees.
// ---------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int VERTEX_COUNT = pip_pkg::VERTEX_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [pip_pkg::SLOT_W-1:0]         vertex_slot_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o
);

  localparam int AW = $clog2(VERTEX_COUNT);

  // Command and status between sequencer and datapath
  pip_pkg::pip_cmd_t cmd;
  pip_pkg::pip_sts_t sts;
  logic [AW-1:0]     rd_addr;

  // Sequencer: handshakes, sweep counter, output register
  pip_ctrl #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o),
    .cmd_o        (cmd),
    .rd_addr_o    (rd_addr),
    .sts_i        (sts)
  );

  // Datapath: vertex memory, bounding box, crossing products and parity
  pip_dp #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .vertex_slot_i (vertex_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .sts_o         (sts)
  );

endmodule

>>> verif/point_in_polygon_test_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_test_checker
// Watches both channels of the polygon tester, predicts every result word
// from its own vertex store and compares it in order with what comes out.
// ---------------------------------------------------------------------------
module point_in_polygon_test_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               kind_i,
  input  logic [pip_pkg::SLOT_W-1:0]         vertex_slot_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic                               inside_res_i,
  output int                                 mismatch_count_o,
  output int                                 pending_count_o
);

  localparam int VERTEX_COUNT = pip_pkg::VERTEX_COUNT_DEF;

  logic signed [pip_pkg::COORD_W-1:0] corner_x [VERTEX_COUNT];
  logic signed [pip_pkg::COORD_W-1:0] corner_y [VERTEX_COUNT];
  bit inside_expected [$];
  int mismatches;

  // Box reject, then even-odd crossing count with the exact cross-multiplied
  // comparison in place of the division.
  function automatic bit polygon_contains(input longint px, input longint py);
    longint min_x, max_x, min_y, max_y;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    bit parity;
    bit left_of;
    int j;
    min_x = longint'(corner_x[0]);
    max_x = longint'(corner_x[0]);
    min_y = longint'(corner_y[0]);
    max_y = longint'(corner_y[0]);
    for (int i = 1; i < VERTEX_COUNT; i++) begin
      if (corner_x[i] < min_x) min_x = longint'(corner_x[i]);
      if (corner_x[i] > max_x) max_x = longint'(corner_x[i]);
      if (corner_y[i] < min_y) min_y = longint'(corner_y[i]);
      if (corner_y[i] > max_y) max_y = longint'(corner_y[i]);
    end
    if (px < min_x || py < min_y || px > max_x || py > max_y) return 1'b0;
    parity = 1'b0;
    j = VERTEX_COUNT - 1;
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      xi = longint'(corner_x[i]);
      yi = longint'(corner_y[i]);
      xj = longint'(corner_x[j]);
      yj = longint'(corner_y[j]);
      if ((yi >= py) != (yj >= py)) begin
        dy = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        left_of = (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
        if (left_of) parity = !parity;
      end
      j = i;
    end
    return parity;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
        corner_x[i] = '0;
        corner_y[i] = '0;
      end
      inside_expected.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // Retire the output word first: an input taken at this same edge
      // can never be answered at it.
      if (out_valid_i && !out_stall_i) begin
        if (inside_expected.size() == 0) begin
          $display("%0t: result word with none expected: expected none, actual inside_res=%0b",
                   $time, inside_res_i);
          mismatches++;
        end else begin
          want = inside_expected.pop_front();
          if (inside_res_i !== want) begin
            $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                     $time, want, inside_res_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == pip_pkg::KIND_LOAD) begin
          if (vertex_slot_i < VERTEX_COUNT) begin
            corner_x[vertex_slot_i] = coord_x_i;
            corner_y[vertex_slot_i] = coord_y_i;
          end
          inside_expected.push_back(1'b0);
        end else begin
          inside_expected.push_back(polygon_contains(longint'(coord_x_i),
                                                     longint'(coord_y_i)));
        end
      end
      mismatch_count_o <= mismatches;
      pending_count_o <= inside_expected.size();
    end
  end

endmodule

>>> verif/point_in_polygon_test_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_test_test
// Drives vertex loads and point queries into the polygon tester under
// several idle and stall patterns, with a long output hold-off once; the
// checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module point_in_polygon_test_test;

  localparam int VERTEX_COUNT    = pip_pkg::VERTEX_COUNT_DEF;
  localparam int CW              = pip_pkg::COORD_W;
  localparam int SW              = pip_pkg::SLOT_W;
  localparam int PHASE_WORDS     = 125;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 3 * (VERTEX_COUNT + 6);
  localparam longint COORD_MIN   = -524288;
  localparam longint COORD_SPAN  = 1048575;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic                               kind_i = pip_pkg::KIND_LOAD;
  logic [pip_pkg::SLOT_W-1:0]         vertex_slot_i = '0;
  logic signed [pip_pkg::COORD_W-1:0] coord_x_i = '0;
  logic signed [pip_pkg::COORD_W-1:0] coord_y_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic                               inside_res_o;

  int mismatch_count;
  int pending_count;

  // Traffic shaping, set per phase by the stimulus process.
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  pressure_go = 1'b0;
  bit  hold_off = 1'b0;
  int  words_sent = 0;
  int  cycle_count = 0;

  // Shadow of the loaded polygon, used only to aim queries near it.
  logic signed [pip_pkg::COORD_W-1:0] shadow_x [VERTEX_COUNT];
  logic signed [pip_pkg::COORD_W-1:0] shadow_y [VERTEX_COUNT];

  // Region the current random polygon lives in.
  longint region_x_lo, region_y_lo, region_span;
  int     region_grid;

  point_in_polygon_test uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .vertex_slot_i (vertex_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_o  (inside_res_o)
  );

  point_in_polygon_test_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .vertex_slot_i    (vertex_slot_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .inside_res_i     (inside_res_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("point_in_polygon_test_test failed");
      $finish;
    end
  end

  // Receiver: stall at random, or solidly during the hold-off.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // Hold off the output for a long stretch once asked, so the block fills
  // up and backs up into its input while the sender keeps offering words.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Offer one word; called and returning at a falling edge. Idle cycles
  // carry junk payload with valid low; once valid is up the payload holds
  // until the word is taken.
  task automatic send_word(input logic kind, input logic [pip_pkg::SLOT_W-1:0] slot,
                           input logic signed [pip_pkg::COORD_W-1:0] x,
                           input logic signed [pip_pkg::COORD_W-1:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i    <= 1'b0;
      kind_i        <= 1'($urandom);
      vertex_slot_i <= SW'($urandom);
      coord_x_i     <= CW'($urandom);
      coord_y_i     <= CW'($urandom);
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    vertex_slot_i <= slot;
    coord_x_i     <= x;
    coord_y_i     <= y;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic load_vertex(input logic [pip_pkg::SLOT_W-1:0] slot,
                             input logic signed [pip_pkg::COORD_W-1:0] x,
                             input logic signed [pip_pkg::COORD_W-1:0] y);
    if (slot < VERTEX_COUNT) begin
      shadow_x[slot] = x;
      shadow_y[slot] = y;
    end
    send_word(pip_pkg::KIND_LOAD, slot, x, y);
  endtask

  // The slot field is ignored on a query: fill it at random.
  task automatic query_point(input logic signed [pip_pkg::COORD_W-1:0] x,
                             input logic signed [pip_pkg::COORD_W-1:0] y);
    send_word(pip_pkg::KIND_QUERY, SW'($urandom), x, y);
  endtask

  // Pick a coordinate inside the region; on a grid the picks repeat, which
  // gives horizontal edges and points sitting on vertices and edges.
  function automatic logic signed [pip_pkg::COORD_W-1:0] pick_coord(input longint lo,
                                                                    input int grid);
    longint step;
    if (grid > 0) begin
      step = region_span / grid;
      return CW'(lo + longint'($urandom_range(0, grid)) * step);
    end
    return CW'(lo + longint'($urandom_range(0, 32'(region_span))));
  endfunction

  // New region: anything from a few LSBs wide to the full coordinate range.
  task automatic new_region();
    int k;
    k = $urandom_range(3, 20);
    region_span = (longint'(1) << k) - 1;
    region_x_lo = COORD_MIN + longint'($urandom_range(0, 32'(COORD_SPAN - region_span)));
    region_y_lo = COORD_MIN + longint'($urandom_range(0, 32'(COORD_SPAN - region_span)));
    region_grid = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
  endtask

  task automatic random_query();
    int dice;
    int v;
    int grid;
    dice = $urandom_range(0, 99);
    v = $urandom_range(0, VERTEX_COUNT - 1);
    grid = $urandom_range(0, 1) ? region_grid : 0;
    if (dice < 60)
      query_point(pick_coord(region_x_lo, grid), pick_coord(region_y_lo, grid));
    else if (dice < 80)
      query_point(CW'(shadow_x[v] + $signed($urandom_range(0, 4)) - 2), shadow_y[v]);
    else if (dice < 90)
      query_point(shadow_x[v], shadow_y[v]);
    else
      query_point(CW'($urandom), CW'($urandom));
  endtask

  initial begin
    int phase_goal;
    int dice;
    int send_table [4];
    int stall_table [4];

    send_table  = '{0, 72, 0, 31};
    stall_table = '{0, 0, 72, 31};
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    region_x_lo = COORD_MIN;
    region_y_lo = COORD_MIN;
    region_span = COORD_SPAN;
    region_grid = 4;

    // Hold reset, then release it away from the rising edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Fresh polygon is all (0, 0): degenerate box with the
    // point on it, and every edge horizontal.
    query_point(20'sd0, 20'sd0);
    query_point(20'sd524287, -20'sd524288);
    // Extreme square in the first slots and slot 15 on the right box edge; the rest stay at the origin.
    load_vertex(4'd0, -20'sd524288, -20'sd524288);
    load_vertex(4'd1, 20'sd524287, -20'sd524288);
    load_vertex(4'd2, 20'sd524287, 20'sd524287);
    load_vertex(4'd3, -20'sd524288, 20'sd524287);
    load_vertex(4'd15, 20'sd524287, 20'sd0);
    query_point(20'sd0, 20'sd0);
    query_point(-20'sd524288, -20'sd524288);
    query_point(20'sd524287, 20'sd524287);
    query_point(20'sd100, 20'sd20);
    query_point(-20'sd300000, 20'sd200000);
    // On the right box edge, at and next to a vertex height.
    query_point(20'sd524287, -20'sd1);
    query_point(20'sd524287, 20'sd0);
    load_vertex(4'd7, -20'sd1, -20'sd1);
    query_point(-20'sd2, -20'sd1);
    query_point(-20'sd1, -20'sd524288);
    query_point(20'sd262144, -20'sd262144);

    // Random part, one phase per traffic pattern. The first phase runs
    // without idling and carries the long output hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_table[phase];
      stall_pct = stall_table[phase];
      if (phase == 0) pressure_go = 1'b1;
      phase_goal = words_sent + PHASE_WORDS;
      while (words_sent < phase_goal) begin
        dice = $urandom_range(0, 99);
        if (dice < 12) begin
          // Whole new polygon in slot order, then probe it.
          new_region();
          for (int i = 0; i < VERTEX_COUNT; i++)
            load_vertex(SW'(i), pick_coord(region_x_lo, region_grid),
                        pick_coord(region_y_lo, region_grid));
          repeat ($urandom_range(3, 8)) random_query();
        end else if (dice < 40) begin
          repeat ($urandom_range(1, 3))
            load_vertex(SW'($urandom_range(0, VERTEX_COUNT - 1)),
                        pick_coord(region_x_lo, region_grid),
                        pick_coord(region_y_lo, region_grid));
        end else if (dice < 90) begin
          repeat ($urandom_range(2, 8)) random_query();
        end else begin
          // Noise: a stray vertex anywhere breaks the polygon's shape.
          load_vertex(SW'($urandom), CW'($urandom), CW'($urandom));
        end
      end
    end

    // Drop valid, let the receiver run free and drain every expected word.
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("point_in_polygon_test_test passed");
    else
      $display("point_in_polygon_test_test failed");
    $finish;
  end

endmodule
